@@ rtl/core/snorcp_pkg.sv @@
package snorcp_pkg;

  // Flash geometry and request caps (powers of two for page and sector)
  localparam int unsigned PAGE_BYTES        = 256;
  localparam int unsigned SECTOR_BYTES      = 4096;
  localparam int unsigned MAX_WRITE_BYTES   = 4096;
  localparam int unsigned MAX_ERASE_SECTORS = 256;
  localparam int unsigned MAX_CMDS          = 32;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned LA_W   = 24;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned CAP_W  = 25;
  localparam int unsigned CMD_W  = 8;
  localparam int unsigned FA_W   = 24;
  localparam int unsigned USED_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 25'd8388608;
  localparam logic [CAP_W-1:0] FULL_SPAN = 25'd16777216;

  localparam logic [USED_W-1:0] BLK64_SECTORS = 5'd16;
  localparam logic [USED_W-1:0] BLK32_SECTORS = 5'd8;
  localparam logic [USED_W-1:0] ONE_SECTOR    = 5'd1;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_ERASE = 2'd2;

  localparam logic [CMD_W-1:0] CMD_NONE      = 8'h00;
  localparam logic [CMD_W-1:0] CMD_READ      = 8'h0b;
  localparam logic [CMD_W-1:0] CMD_PROGRAM   = 8'h02;
  localparam logic [CMD_W-1:0] CMD_ERASE_4K  = 8'h20;
  localparam logic [CMD_W-1:0] CMD_ERASE_32K = 8'h52;
  localparam logic [CMD_W-1:0] CMD_ERASE_64K = 8'hd8;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [LA_W-1:0]  logical_address;
    logic [LEN_W-1:0] request_length;
  } req_t;

  typedef struct packed {
    logic [CMD_W-1:0] command_byte;
    logic [FA_W-1:0]  flash_address;
    logic [LEN_W-1:0] byte_count;
    logic             dummy_bytes;
    logic             needs_write_enable;
    logic             error;
    logic             last;
  } cmd_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic check;
    logic step;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;
    logic final_cmd;
  } stat_t;

endpackage

@@ rtl/core/snorcp_stream_if.sv @@
interface snorcp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/spi_nor_command_planner.sv @@
// A request is loaded on accept and checked in S_CHECK; its first command is
// registered in S_EMIT once the output slot is free. For N commands (N <= 32),
// the sequencing FSM issues one command per cycle while the sink keeps ready high.
// A rejected request produces a single error command.
// Reset: FSM idle, no command pending, capacity register = 8388608 bytes.
module spi_nor_command_planner #(
  parameter int unsigned PageBytes       = snorcp_pkg::PAGE_BYTES,
  parameter int unsigned SectorBytes     = snorcp_pkg::SECTOR_BYTES,
  parameter int unsigned MaxWriteBytes   = snorcp_pkg::MAX_WRITE_BYTES,
  parameter int unsigned MaxEraseSectors = snorcp_pkg::MAX_ERASE_SECTORS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [snorcp_pkg::CAP_W-1:0]  cfg_wdata_i,
  snorcp_stream_if.sink                 req_i,
  snorcp_stream_if.source               cmd_o
);

  snorcp_pkg::ctrl_t ctrl;
  snorcp_pkg::stat_t stat;
  snorcp_pkg::req_t  req_payload;
  snorcp_pkg::cmd_t  cmd_payload;
  logic              req_ready;
  logic              cmd_valid;

  assign req_payload   = req_i.payload;
  assign req_i.ready   = req_ready;
  assign cmd_o.valid   = cmd_valid;
  assign cmd_o.payload = cmd_payload;

  snorcp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  snorcp_dp #(
    .PageBytes       (PageBytes),
    .SectorBytes     (SectorBytes),
    .MaxWriteBytes   (MaxWriteBytes),
    .MaxEraseSectors (MaxEraseSectors)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_payload),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_o.ready),
    .cmd_o       (cmd_payload)
  );

  // a request locks out the next one until its commands are sequenced
  a_req_lockout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_ready |=> !req_ready)
    else $error("request accepted back to back");

  // a taken non-final command is always followed by the next one
  a_cmd_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_o.ready && !cmd_payload.last |=> cmd_valid)
    else $error("gap inside a command run");

  // a rejection is a single, empty command
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_payload.error |->
      cmd_payload.last && cmd_payload.command_byte == snorcp_pkg::CMD_NONE &&
      !cmd_payload.needs_write_enable && cmd_payload.byte_count == '0)
    else $error("malformed error command");

  // commands are only produced while no new request can enter
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.step |-> !req_ready)
    else $error("command issued while idle");

endmodule

@@ rtl/core/snorcp_ctrl.sv @@
module snorcp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  snorcp_pkg::stat_t  stat_i,
  output snorcp_pkg::ctrl_t  ctrl_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_EMIT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    ctrl_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        ctrl_o.load = req_valid_i;
        if (req_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        ctrl_o.check = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        ctrl_o.step = stat_i.slot_free;
        if (stat_i.slot_free && stat_i.final_cmd) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/snorcp_dp.sv @@
module snorcp_dp #(
  parameter int unsigned PageBytes       = snorcp_pkg::PAGE_BYTES,
  parameter int unsigned SectorBytes     = snorcp_pkg::SECTOR_BYTES,
  parameter int unsigned MaxWriteBytes   = snorcp_pkg::MAX_WRITE_BYTES,
  parameter int unsigned MaxEraseSectors = snorcp_pkg::MAX_ERASE_SECTORS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [snorcp_pkg::CAP_W-1:0]       cfg_wdata_i,
  input  snorcp_pkg::req_t                   req_i,
  input  snorcp_pkg::ctrl_t                  ctrl_i,
  output snorcp_pkg::stat_t                  stat_o,
  output logic                               cmd_valid_o,
  input  logic                               cmd_ready_i,
  output snorcp_pkg::cmd_t                   cmd_o
);

  // page and sector sizes are powers of two
  localparam int unsigned LenW  = snorcp_pkg::LEN_W;
  localparam int unsigned CapW  = snorcp_pkg::CAP_W;
  localparam int unsigned PgLg  = $clog2(PageBytes);
  localparam int unsigned SecLg = $clog2(SectorBytes);
  // block (16 bits) and sector (4 bits) scaled by the sector size, plus room for the page part
  localparam int unsigned PaW   = 21 + SecLg;
  localparam int unsigned SpanW = LenW + SecLg;
  localparam int unsigned RoomW = PgLg + 1;
  localparam int unsigned UsedW = snorcp_pkg::USED_W;
  localparam int unsigned SumW  = LenW + 1;

  logic [CapW-1:0]                  cap_q;
  logic [snorcp_pkg::OP_W-1:0]      op_q;
  logic [PaW-1:0]                   addr_q, addr_d;
  logic [LenW-1:0]                  len_q, len_d;
  logic                             bad_q, bad_d;
  logic                             out_valid_q;
  snorcp_pkg::cmd_t                 out_q, out_d;

  // decode of the packed address
  logic [PaW-1:0] sec_base, page_part, phys, phys_ld;

  always_comb begin
    sec_base  = PaW'(req_i.logical_address[23:4]) << SecLg;
    page_part = PaW'(req_i.logical_address[3:0]) << PgLg;
    phys      = sec_base + page_part;
    phys_ld   = phys;
    if (req_i.opcode == snorcp_pkg::OP_ERASE) begin
      phys_ld = {phys[PaW-1:SecLg], {SecLg{1'b0}}};
    end
  end

  // range and cap checks
  logic [SpanW-1:0] span;
  logic [PaW:0]     addr_end, cap_ext;
  logic [CapW-1:0]  cap_eff;
  logic [SumW-1:0]  page_sum;
  logic             too_many;

  always_comb begin
    span = (op_q == snorcp_pkg::OP_ERASE) ? {len_q, {SecLg{1'b0}}} : SpanW'(len_q);
    addr_end = {1'b0, addr_q} + (PaW + 1)'(span);
    cap_eff  = (cap_q > snorcp_pkg::FULL_SPAN) ? snorcp_pkg::FULL_SPAN : cap_q;
    cap_ext  = (PaW + 1)'(cap_eff);
    // offset of the last byte touched by a write from the start of its first page
    page_sum = SumW'(addr_q[PgLg-1:0]) + SumW'(len_q) - SumW'(1);
    too_many = (page_sum >> PgLg) >= SumW'(snorcp_pkg::MAX_CMDS);
    bad_d = (len_q == '0) || ({1'b0, addr_q} >= cap_ext) || (addr_end > cap_ext);
    unique case (op_q)
      snorcp_pkg::OP_READ: ;
      snorcp_pkg::OP_WRITE: begin
        if (len_q > LenW'(MaxWriteBytes) || too_many) bad_d = 1'b1;
      end
      snorcp_pkg::OP_ERASE: begin
        if (len_q > LenW'(MaxEraseSectors)) bad_d = 1'b1;
      end
      default: bad_d = 1'b1;
    endcase
  end

  // one command per step
  logic [RoomW-1:0] room;
  logic [LenW-1:0]  chunk;
  logic             wr_last;
  logic [UsedW-1:0] used;
  logic [snorcp_pkg::CMD_W-1:0] erase_cmd;
  logic             er_last;
  logic             final_cmd;

  always_comb begin
    room    = RoomW'(PageBytes) - RoomW'(addr_q[PgLg-1:0]);
    wr_last = len_q <= LenW'(room);
    chunk   = wr_last ? len_q : LenW'(room);

    priority if (addr_q[SecLg+3:0] == '0 && len_q >= LenW'(snorcp_pkg::BLK64_SECTORS)) begin
      used      = snorcp_pkg::BLK64_SECTORS;
      erase_cmd = snorcp_pkg::CMD_ERASE_64K;
    end else if (addr_q[SecLg+2:0] == '0 &&
                 len_q >= LenW'(snorcp_pkg::BLK32_SECTORS)) begin
      used      = snorcp_pkg::BLK32_SECTORS;
      erase_cmd = snorcp_pkg::CMD_ERASE_32K;
    end else begin
      used      = snorcp_pkg::ONE_SECTOR;
      erase_cmd = snorcp_pkg::CMD_ERASE_4K;
    end
    er_last = len_q == LenW'(used);

    out_d                    = '0;
    out_d.flash_address      = addr_q[snorcp_pkg::FA_W-1:0];
    out_d.last               = 1'b1;
    addr_d                   = addr_q;
    len_d                    = len_q;
    final_cmd                = 1'b1;
    if (bad_q) begin
      out_d               = '0;
      out_d.error         = 1'b1;
      out_d.last          = 1'b1;
    end else begin
      unique case (op_q)
        snorcp_pkg::OP_READ: begin
          out_d.command_byte = snorcp_pkg::CMD_READ;
          out_d.byte_count   = len_q;
          out_d.dummy_bytes  = 1'b1;
        end
        snorcp_pkg::OP_WRITE: begin
          out_d.command_byte       = snorcp_pkg::CMD_PROGRAM;
          out_d.byte_count         = chunk;
          out_d.needs_write_enable = 1'b1;
          out_d.last               = wr_last;
          final_cmd                = wr_last;
          addr_d                   = addr_q + PaW'(chunk);
          len_d                    = len_q - chunk;
        end
        snorcp_pkg::OP_ERASE: begin
          out_d.command_byte       = erase_cmd;
          out_d.needs_write_enable = 1'b1;
          out_d.last               = er_last;
          final_cmd                = er_last;
          addr_d                   = addr_q + (PaW'(used) << SecLg);
          len_d                    = len_q - LenW'(used);
        end
        default: begin
          out_d       = '0;
          out_d.error = 1'b1;
          out_d.last  = 1'b1;
        end
      endcase
    end
  end

  assign stat_o.slot_free = !out_valid_q || cmd_ready_i;
  assign stat_o.final_cmd = final_cmd;
  assign cmd_valid_o      = out_valid_q;
  assign cmd_o            = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= snorcp_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (ctrl_i.step) begin
        out_valid_q <= 1'b1;
      end else if (cmd_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q   <= req_i.opcode;
      addr_q <= phys_ld;
      len_q  <= req_i.request_length;
    end else if (ctrl_i.step) begin
      addr_q <= addr_d;
      len_q  <= len_d;
    end
    if (ctrl_i.check) bad_q <= bad_d;
    if (ctrl_i.step) out_q <= out_d;
  end

endmodule
